// ===== sv/ppre_pkg.sv =====
// ----------------------------------------------------------------------------
// ppre_pkg
// Shared widths, register map, configuration and result types for the
// projection profile run extractor.
// ----------------------------------------------------------------------------
package ppre_pkg;

  localparam int PROFILE_W   = 20;
  localparam int LTH_W       = 13;
  localparam int LML_W       = 14;
  localparam int SUM_W       = 26;
  localparam int SW_W        = 13;
  localparam int START_W     = 13;
  localparam int LENF_W      = 14;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 26;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam int DEF_MAX_HEIGHT      = 8192;
  localparam int DEF_MAX_STRIP_WIDTH = 4096;

  // divide by 255 as multiply by ceil(2^28 / 255), exact for 20-bit inputs
  localparam int GRAY_SHIFT   = 28;
  localparam int GRAY_RECIP_W = 21;
  localparam logic [GRAY_RECIP_W-1:0] GRAY_RECIP = 21'd1052689;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_THRESHOLD  = 3'd0,
    REG_LOW_MIN_LENGTH = 3'd1,
    REG_MIN_PIXELS     = 3'd2,
    REG_GRAY_MODE      = 3'd3,
    REG_STRIP_WIDTH    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [LTH_W-1:0] low_threshold;
    logic [LML_W-1:0] low_min_length;
    logic [SUM_W-1:0] min_pixels;
    logic             gray_mode;
    logic [SW_W-1:0]  strip_width;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    low_threshold:  13'd2,
    low_min_length: 14'd16,
    min_pixels:     26'd0,
    gray_mode:      1'b0,
    strip_width:    13'd64
  };

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LENF_W-1:0]  len;
    logic               term;
    logic               last;
  } res_t;

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_sum = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

// ===== sv/projection_profile_run_extractor_top.sv =====
// ----------------------------------------------------------------------------
// projection_profile_run_extractor_top
// Segments a column strip's row projection profile into runs of nonzero rows,
// suppressing thin-line residue, and reports qualifying runs plus a strip
// terminator.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata profile_value, tlast last_row
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata run_start/run_length,
//                                               tuser is_terminator, tlast last_of_item
//   cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// One row per cycle sustained while the result FIFO has room; a row's results
// reach m_axis through the gray conversion register, then the run tracker
// into a 4-entry FIFO.
// Each row yields up to two results, drained one per cycle while m_axis_tready is high.
// Synchronous reset clears all strip state and loads register defaults.
// s_axis stalls only while the result FIFO lacks room for two results.
// ----------------------------------------------------------------------------
module projection_profile_run_extractor_top #(
  parameter int MAX_HEIGHT      = ppre_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_STRIP_WIDTH = ppre_pkg::DEF_MAX_STRIP_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ppre_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // profile_value
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ppre_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // run_start, run_length
  output logic [0:0]                       m_axis_tuser,  // is_terminator
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ppre_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppre_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ppre_pkg::*;

  cfg_t                 cfg;
  logic                 g_valid;
  logic                 g_ready;
  logic [PROFILE_W-1:0] g_value;
  logic                 g_last;
  res_t                 out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LOW_THRESHOLD:  cfg.low_threshold  <= cfg_data[LTH_W-1:0];
        REG_LOW_MIN_LENGTH: cfg.low_min_length <= cfg_data[LML_W-1:0];
        REG_MIN_PIXELS:     cfg.min_pixels     <= cfg_data[SUM_W-1:0];
        REG_GRAY_MODE:      cfg.gray_mode      <= cfg_data[0];
        REG_STRIP_WIDTH:    cfg.strip_width    <= cfg_data[SW_W-1:0];
        default: ;
      endcase
    end
  end

  ppre_gray #(
    .MAX_STRIP_WIDTH(MAX_STRIP_WIDTH)
  ) u_gray (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_value  (s_axis_tdata[PROFILE_W-1:0]),
    .in_last   (s_axis_tlast),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .out_value (g_value),
    .out_last  (g_last)
  );

  ppre_track #(
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .in_value  (g_value),
    .in_last   (g_last),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = OUT_TDATA_W'({out_res.len, out_res.start});
  assign m_axis_tuser = out_res.term;
  assign m_axis_tlast = out_res.last;

endmodule

// ===== sv/ppre_gray.sv =====
// ----------------------------------------------------------------------------
// ppre_gray
// Input register stage: turns a gray projection sum into a dark count
// (clamped width minus sum/255) or passes a binary count through.
// ----------------------------------------------------------------------------
module ppre_gray #(
  parameter int MAX_STRIP_WIDTH = ppre_pkg::DEF_MAX_STRIP_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ppre_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ppre_pkg::PROFILE_W-1:0] in_value,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ppre_pkg::PROFILE_W-1:0] out_value,
  output logic                           out_last
);
  import ppre_pkg::*;

  localparam int MSW_W  = $clog2(MAX_STRIP_WIDTH + 1);
  localparam int W_W    = (MSW_W > SW_W) ? MSW_W : SW_W;
  localparam int PROD_W = PROFILE_W + GRAY_RECIP_W;
  localparam int QUOT_W = PROD_W - GRAY_SHIFT;
  localparam logic [W_W-1:0] MSW = W_W'(MAX_STRIP_WIDTH);

  logic [PROD_W-1:0]    prod;
  logic [QUOT_W-1:0]    quot;
  logic [W_W-1:0]       width_clamp;
  logic [W_W-1:0]       quot_ext;
  logic [PROFILE_W-1:0] value_next;

  always_comb begin
    prod        = PROD_W'(in_value) * PROD_W'(GRAY_RECIP);
    quot        = prod[PROD_W-1:GRAY_SHIFT];
    width_clamp = (W_W'(cfg.strip_width) > MSW) ? MSW : W_W'(cfg.strip_width);
    quot_ext    = W_W'(quot);
    if (cfg.gray_mode) begin
      value_next = (width_clamp > quot_ext) ? PROFILE_W'(width_clamp - quot_ext) : '0;
    end else begin
      value_next = in_value;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_value <= value_next;
      out_last  <= in_last;
    end
  end

endmodule

// ===== sv/ppre_track.sv =====
// ----------------------------------------------------------------------------
// ppre_track
// Run tracker: keeps the open run and the pending thin-line run, closes and
// qualifies runs, and queues up to two results per row in a small FIFO.
// ----------------------------------------------------------------------------
module ppre_track #(
  parameter int MAX_HEIGHT = ppre_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ppre_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ppre_pkg::PROFILE_W-1:0] in_value,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ppre_pkg::res_t                 out_res
);
  import ppre_pkg::*;

  localparam int RI_W       = $clog2(MAX_HEIGHT);
  localparam int LEN_W      = $clog2(MAX_HEIGHT + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_HEIGHT);
  localparam logic [RI_W-1:0]  RI_LAST = RI_W'(MAX_HEIGHT - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(FIFO_DEPTH - 2);

  typedef struct packed {
    logic              main_active;
    logic [RI_W-1:0]   main_start;
    logic [LEN_W-1:0]  main_len;
    logic [SUM_W-1:0]  main_sum;
    logic [RI_W-1:0]   low_start;
    logic [LEN_W-1:0]  low_len;
    logic [SUM_W-1:0]  low_sum;
    logic              low_zeroed;
  } trk_state_t;

  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_len = (s > {1'b0, LEN_MAX}) ? LEN_MAX : s[LEN_W-1:0];
  endfunction

  function automatic trk_state_t clear_main(input trk_state_t s);
    trk_state_t r;
    r             = s;
    r.main_active = 1'b0;
    r.main_start  = '0;
    r.main_len    = '0;
    r.main_sum    = '0;
    clear_main    = r;
  endfunction

  function automatic trk_state_t settle_low(input trk_state_t s);
    trk_state_t r;
    r = s;
    if (r.low_len != '0 && !r.low_zeroed) begin
      if (!r.main_active) begin
        r.main_active = 1'b1;
        r.main_start  = r.low_start;
        r.main_len    = '0;
        r.main_sum    = '0;
      end
      r.main_len = sat_len(r.main_len, r.low_len);
      r.main_sum = sat_sum(r.main_sum, r.low_sum);
    end
    r.low_start  = '0;
    r.low_len    = '0;
    r.low_sum    = '0;
    r.low_zeroed = 1'b0;
    settle_low   = r;
  endfunction

  trk_state_t        st;
  trk_state_t        st_next;
  logic [RI_W-1:0]   row_index;
  logic [RI_W-1:0]   row_index_next;
  logic              emit;
  logic [RI_W-1:0]   emit_start;
  logic [LEN_W-1:0]  emit_len;
  logic [SUM_W-1:0]  v_sum;
  logic              is_low;
  logic              fire;
  logic              pop;
  res_t              run_res;
  res_t              term_res;
  res_t              fifo [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic [1:0]        nwr;

  always_comb begin
    st_next    = st;
    emit       = 1'b0;
    emit_start = '0;
    emit_len   = '0;
    v_sum      = SUM_W'(in_value);
    is_low     = (in_value != '0) && (in_value <= PROFILE_W'(cfg.low_threshold));

    if (is_low) begin
      if (st_next.low_len == '0) begin
        st_next.low_start = row_index;
      end
      st_next.low_len = sat_len(st_next.low_len, LEN_W'(1));
      st_next.low_sum = sat_sum(st_next.low_sum, v_sum);
      if (!st_next.low_zeroed && (32'(st_next.low_len) >= 32'(cfg.low_min_length))) begin
        st_next.low_zeroed = 1'b1;
        if (st_next.main_active && st_next.main_sum >= cfg.min_pixels) begin
          emit       = 1'b1;
          emit_start = st_next.main_start;
          emit_len   = st_next.main_len;
        end
        st_next = clear_main(st_next);
      end
    end else begin
      st_next = settle_low(st_next);
      if (in_value == '0) begin
        if (st_next.main_active && st_next.main_sum >= cfg.min_pixels) begin
          emit       = 1'b1;
          emit_start = st_next.main_start;
          emit_len   = st_next.main_len;
        end
        st_next = clear_main(st_next);
      end else begin
        if (!st_next.main_active) begin
          st_next.main_active = 1'b1;
          st_next.main_start  = row_index;
          st_next.main_len    = '0;
          st_next.main_sum    = '0;
        end
        st_next.main_len = sat_len(st_next.main_len, LEN_W'(1));
        st_next.main_sum = sat_sum(st_next.main_sum, v_sum);
      end
    end

    if (in_last) begin
      st_next = settle_low(st_next);
      if (st_next.main_active && st_next.main_sum >= cfg.min_pixels) begin
        emit       = 1'b1;
        emit_start = st_next.main_start;
        emit_len   = st_next.main_len;
      end
      st_next        = '0;
      row_index_next = '0;
    end else begin
      row_index_next = (row_index == RI_LAST) ? '0 : row_index + 1'b1;
    end
  end

  always_comb begin
    run_res.start  = START_W'(emit_start);
    run_res.len    = LENF_W'(emit_len);
    run_res.term   = 1'b0;
    run_res.last   = !in_last;
    term_res.start = '0;
    term_res.len   = '0;
    term_res.term  = 1'b1;
    term_res.last  = 1'b1;
  end

  assign in_ready  = count <= CNT_ROOM;
  assign fire      = in_valid && in_ready;
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign out_res   = fifo[rd_ptr];
  assign nwr       = fire ? (2'(emit) + 2'(in_last)) : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      row_index <= '0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
    end else begin
      if (fire) begin
        st        <= st_next;
        row_index <= row_index_next;
      end
      wr_ptr <= wr_ptr + PTR_W'(nwr);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(nwr) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      fifo[wr_ptr] <= run_res;
    end
    if (fire && in_last) begin
      fifo[wr_ptr + PTR_W'(emit)] <= term_res;
    end
  end

  a_main_len_tracks_active: assert property (@(posedge clk) disable iff (rst)
    st.main_active == (st.main_len != '0))
    else $error("open run length disagrees with active flag");

  a_zeroed_has_rows: assert property (@(posedge clk) disable iff (rst)
    st.low_zeroed |-> st.low_len != '0)
    else $error("zeroed residue run without rows");

  a_strip_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && in_last |=> row_index == '0 && !st.main_active && st.low_len == '0)
    else $error("strip state not cleared after last row");

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("result FIFO overflow");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the projection profile run extractor. Row samples
// are queued per phase under varying register settings, driven on s_axis with
// random gaps, and each accepted row is run through a behavioral run tracker
// that queues the expected run and terminator results. Results taken from
// m_axis under random stalls are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import ppre_pkg::*;

  localparam int TIMEOUT_CYCLES = 500000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int GRAY_DIV       = 255;
  localparam logic [PROFILE_W-1:0] PROFILE_MAX = '1;

  typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_LIGHT} idle_style_t;
  typedef enum int {SEG_ZERO, SEG_RESIDUE, SEG_HIGH, SEG_HEAVY, SEG_NOISE} seg_kind_t;

  typedef struct {
    logic [PROFILE_W-1:0] value;
    bit                   last;
  } row_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_LOW_THRESHOLD;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  projection_profile_run_extractor_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  row_item_t   pending_rows[$];
  res_t        expected_runs[$];
  int unsigned rows_queued = 0;
  int unsigned rows_taken = 0;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  idle_style_t sender_style = IDLE_NONE;
  idle_style_t receiver_style = IDLE_NONE;

  // run tracker state
  cfg_t        shadow = CFG_RESET;
  int unsigned row_idx = 0;
  bit          open_active = 1'b0;
  int unsigned open_start = 0;
  int unsigned open_len = 0;
  int unsigned open_sum = 0;
  int unsigned resid_start = 0;
  int unsigned resid_len = 0;
  int unsigned resid_sum = 0;
  bit          resid_zeroed = 1'b0;
  int unsigned row_hits = 0;

  function automatic int unsigned capped_sum(input int unsigned a, input int unsigned b);
    return (a + b > SUM_MAX) ? SUM_MAX : a + b;
  endfunction

  function automatic int unsigned capped_len(input int unsigned a, input int unsigned b);
    return (a + b > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : a + b;
  endfunction

  function automatic int draw_wait(input idle_style_t style);
    case (style)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 16);
      default:   return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  task automatic push_run(input int unsigned start, input int unsigned len, input bit term);
    res_t r;
    r.start = start[START_W-1:0];
    r.len   = len[LENF_W-1:0];
    r.term  = term;
    r.last  = 1'b0;
    expected_runs.push_back(r);
    row_hits++;
  endtask

  task automatic close_open_run();
    if (open_active && open_sum >= shadow.min_pixels) push_run(open_start, open_len, 1'b0);
    open_active = 1'b0;
    open_start  = 0;
    open_len    = 0;
    open_sum    = 0;
  endtask

  task automatic settle_residue();
    if (resid_len > 0 && !resid_zeroed) begin
      if (!open_active) begin
        open_active = 1'b1;
        open_start  = resid_start;
        open_len    = 0;
        open_sum    = 0;
      end
      open_len = capped_len(open_len, resid_len);
      open_sum = capped_sum(open_sum, resid_sum);
    end
    resid_start  = 0;
    resid_len    = 0;
    resid_sum    = 0;
    resid_zeroed = 1'b0;
  endtask

  task automatic track_row(input logic [PROFILE_W-1:0] pv, input bit last);
    int unsigned w, q, v;
    row_hits = 0;
    if (shadow.gray_mode) begin
      w = (shadow.strip_width > DEF_MAX_STRIP_WIDTH) ? DEF_MAX_STRIP_WIDTH : shadow.strip_width;
      q = pv / GRAY_DIV;
      v = (w > q) ? w - q : 0;
    end else begin
      v = pv;
    end
    if (v != 0 && v <= shadow.low_threshold) begin
      if (resid_len == 0) resid_start = row_idx;
      resid_len = capped_len(resid_len, 1);
      resid_sum = capped_sum(resid_sum, v);
      if (!resid_zeroed && resid_len >= shadow.low_min_length) begin
        resid_zeroed = 1'b1;
        close_open_run();
      end
    end else begin
      settle_residue();
      if (v == 0) begin
        close_open_run();
      end else begin
        if (!open_active) begin
          open_active = 1'b1;
          open_start  = row_idx;
          open_len    = 0;
          open_sum    = 0;
        end
        open_len = capped_len(open_len, 1);
        open_sum = capped_sum(open_sum, v);
      end
    end
    if (last) begin
      settle_residue();
      close_open_run();
      push_run(0, 0, 1'b1);
      row_idx = 0;
    end else begin
      row_idx = (row_idx + 1) % DEF_MAX_HEIGHT;
    end
    if (row_hits > 0) expected_runs[expected_runs.size() - 1].last = 1'b1;
  endtask

  int          gap_left = 0;
  row_item_t   next_row;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_row(s_axis_tdata[PROFILE_W-1:0], s_axis_tlast);
        rows_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_rows.size() != 0) begin
          next_row = pending_rows.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= IN_TDATA_W'(next_row.value);
          s_axis_tlast <= next_row.last;
          gap_left <= draw_wait(sender_style);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  int   stall_left = 0;
  int   stall_draw;
  res_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (expected_runs.size() == 0) begin
        $error("unexpected result: run_start %0d run_length %0d is_terminator %0b",
               m_axis_tdata[START_W-1:0], m_axis_tdata[START_W+LENF_W-1:START_W],
               m_axis_tuser[0]);
        failures++;
      end else begin
        want = expected_runs.pop_front();
        if (m_axis_tdata[START_W-1:0] !== want.start) begin
          $error("run_start expected %0d actual %0d", want.start, m_axis_tdata[START_W-1:0]);
          failures++;
        end
        if (m_axis_tdata[START_W+LENF_W-1:START_W] !== want.len) begin
          $error("run_length expected %0d actual %0d", want.len,
                 m_axis_tdata[START_W+LENF_W-1:START_W]);
          failures++;
        end
        if (m_axis_tuser[0] !== want.term) begin
          $error("is_terminator expected %0b actual %0b", want.term, m_axis_tuser[0]);
          failures++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_of_item expected %0b actual %0b", want.last, m_axis_tlast);
          failures++;
        end
      end
      stall_draw = draw_wait(receiver_style);
      if (stall_draw == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left <= stall_draw - 1;
      end
    end else if (!m_axis_tready) begin
      if (stall_left == 0) m_axis_tready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LOW_THRESHOLD:  shadow.low_threshold  = val[LTH_W-1:0];
      REG_LOW_MIN_LENGTH: shadow.low_min_length = val[LML_W-1:0];
      REG_MIN_PIXELS:     shadow.min_pixels     = val[SUM_W-1:0];
      REG_GRAY_MODE:      shadow.gray_mode      = val[0];
      REG_STRIP_WIDTH:    shadow.strip_width    = val[SW_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input int unsigned thr, input int unsigned min_len,
                              input int unsigned min_pix, input int unsigned gray,
                              input int unsigned width);
    write_reg(REG_LOW_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_LOW_MIN_LENGTH, CFG_DATA_W'(min_len));
    write_reg(REG_MIN_PIXELS, CFG_DATA_W'(min_pix));
    write_reg(REG_GRAY_MODE, CFG_DATA_W'(gray));
    write_reg(REG_STRIP_WIDTH, CFG_DATA_W'(width));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config();
    int unsigned thr, min_len, min_pix, width;
    case ($urandom_range(0, 7))
      0:       thr = 0;
      1:       thr = 1;
      2:       thr = 2;
      3:       thr = 4096;
      4:       thr = 8191;
      5:       thr = $urandom_range(0, 8191);
      default: thr = $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 7))
      0:       min_len = 0;
      1:       min_len = 1;
      2:       min_len = 8192;
      3:       min_len = 16383;
      4:       min_len = $urandom_range(0, 16383);
      default: min_len = $urandom_range(2, 6);
    endcase
    case ($urandom_range(0, 7))
      0:       min_pix = 0;
      1:       min_pix = SUM_MAX;
      2:       min_pix = $urandom & SUM_MAX;
      3:       min_pix = 33554432;
      default: min_pix = $urandom_range(0, 3000);
    endcase
    case ($urandom_range(0, 7))
      0:       width = 0;
      1:       width = 1;
      2:       width = 4096;
      3:       width = 8191;
      4:       width = $urandom_range(0, 8191);
      default: width = $urandom_range(2, 300);
    endcase
    apply_config(thr, min_len, min_pix, $urandom_range(0, 1), width);
  endtask

  task automatic queue_row(input logic [PROFILE_W-1:0] value, input bit last);
    row_item_t r;
    r.value = value;
    r.last  = last;
    pending_rows.push_back(r);
    rows_queued++;
  endtask

  function automatic logic [PROFILE_W-1:0] row_value(input seg_kind_t kind);
    int unsigned thr, w, top, v;
    thr = shadow.low_threshold;
    w   = (shadow.strip_width > DEF_MAX_STRIP_WIDTH) ? DEF_MAX_STRIP_WIDTH : shadow.strip_width;
    top = shadow.gray_mode ? w : PROFILE_MAX;
    case (kind)
      SEG_NOISE:   return ($urandom_range(0, 3) == 0) ? PROFILE_MAX : PROFILE_W'($urandom);
      SEG_ZERO:    v = 0;
      SEG_RESIDUE: v = (thr == 0 || top == 0) ? 0 : $urandom_range(1, (thr < top) ? thr : top);
      SEG_HEAVY:   v = top;
      default: begin
        if (thr >= top) v = top;
        else if ($urandom_range(0, 1) == 0)
          v = $urandom_range(thr + 1, (top - thr > 40) ? thr + 40 : top);
        else v = $urandom_range(thr + 1, top);
      end
    endcase
    if (!shadow.gray_mode) return PROFILE_W'(v);
    if (v == 0) return PROFILE_W'($urandom_range(w * GRAY_DIV, PROFILE_MAX));
    return PROFILE_W'((w - v) * GRAY_DIV + $urandom_range(0, GRAY_DIV - 1));
  endfunction

  task automatic fill_rows(input int count, input int last_odds);
    int done, seg_len, min_len, pick;
    seg_kind_t kind;
    done = 0;
    min_len = shadow.low_min_length;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        kind = SEG_ZERO;
        seg_len = $urandom_range(1, 4);
      end else if (pick < 52) begin
        kind = SEG_RESIDUE;
        if (min_len >= 1 && min_len <= 24 && $urandom_range(0, 1) == 0)
          seg_len = min_len - 1 + $urandom_range(0, 2);
        else seg_len = $urandom_range(1, 6);
        if (seg_len == 0) seg_len = 1;
      end else if (pick < 89) begin
        kind = SEG_HIGH;
        seg_len = $urandom_range(1, 12);
      end else if (pick < 90) begin
        kind = SEG_HEAVY;
        seg_len = $urandom_range(66, 70);
      end else begin
        kind = SEG_NOISE;
        seg_len = $urandom_range(1, 3);
      end
      repeat (seg_len) begin
        queue_row(row_value(kind), last_odds != 0 && $urandom_range(1, last_odds) == 1);
        done++;
      end
    end
  endtask

  task automatic wait_idle();
    while (rows_taken != rows_queued || expected_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    sender_style   = IDLE_FULL;
    receiver_style = IDLE_FULL;
    apply_config(3, 2, 0, 0, 64);
    queue_row(PROFILE_MAX, 1'b0);
    queue_row(0, 1'b0);
    queue_row(1, 1'b0);
    queue_row(50, 1'b0);
    queue_row(2, 1'b0);
    queue_row(3, 1'b0);
    queue_row(0, 1'b0);
    queue_row(7, 1'b0);
    queue_row(1, 1'b1);
    queue_row(0, 1'b1);
    wait_idle();

    // wide strip in gray mode, no residue values
    apply_config(0, 0, 10, 1, 8191);
    queue_row(0, 1'b0);
    queue_row(1044480, 1'b0);
    queue_row(4095 * GRAY_DIV, 1'b0);
    queue_row(PROFILE_MAX, 1'b0);
    queue_row(254, 1'b0);
    queue_row(255, 1'b1);
    wait_idle();

    // zero minimum length with the widest threshold
    apply_config(8191, 0, 33554432, 0, 0);
    queue_row(5, 1'b0);
    queue_row(9000, 1'b0);
    queue_row(8191, 1'b0);
    queue_row(9000, 1'b1);
    wait_idle();

    sender_style   = IDLE_NONE;
    receiver_style = IDLE_NONE;
    apply_config(CFG_RESET.low_threshold, CFG_RESET.low_min_length, CFG_RESET.min_pixels,
                 CFG_RESET.gray_mode, CFG_RESET.strip_width);
    fill_rows(100, 30);
    wait_idle();

    repeat (12) begin
      sender_style   = idle_style_t'($urandom_range(0, 2));
      receiver_style = idle_style_t'($urandom_range(0, 2));
      random_config();
      fill_rows($urandom_range(80, 120), $urandom_range(10, 60));
      wait_idle();
    end

    sender_style   = IDLE_FULL;
    receiver_style = IDLE_LIGHT;
    random_config();
    fill_rows(100, 20);
    wait_idle();

    if (failures == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
